// File: rtl/polynomial_term_accumulate_evaluate_defines.svh
// Assertion macros for the polynomial term accumulator and evaluator.
// Used by the top level; each macro expects clk and rst_n in scope.
`ifndef POLYNOMIAL_TERM_ACCUMULATE_EVALUATE_DEFINES_SVH
`define POLYNOMIAL_TERM_ACCUMULATE_EVALUATE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pte: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pte: next-cycle check failed");

`endif

// File: rtl/pte_pkg.sv
// Package for the polynomial term accumulator and evaluator.
// Holds the item types, the control word types and the microcode table.
`default_nettype none

package pte_pkg;

    typedef struct packed {
        logic               command;
        logic signed [31:0] term_coefficient;
        logic        [3:0]  term_exponent;
        logic signed [31:0] point_x;
    } pte_in_t;

    typedef struct packed {
        logic signed [31:0] eval_point;
        logic signed [31:0] eval_value;
    } pte_out_t;

    localparam logic CMD_ADD_TERM = 1'b0;
    localparam logic CMD_EVALUATE = 1'b1;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_RD_TERM,
        OP_WR_TERM,
        OP_EV_INIT,
        OP_EV_MAC,
        OP_EV_DONE,
        OP_W_LL,
        OP_W_LH,
        OP_W_HL,
        OP_W_ACC
    } pte_op_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_IF_EVAL,
        JMP_IF_WIDE,
        JMP_IF_MORE
    } pte_jmp_t;

    typedef logic [3:0] pte_pc_t;

    localparam pte_pc_t STEP_IDLE     = 4'd0;
    localparam pte_pc_t STEP_DISPATCH = 4'd1;
    localparam pte_pc_t STEP_WRITE    = 4'd2;
    localparam pte_pc_t STEP_EV_INIT  = 4'd3;
    localparam pte_pc_t STEP_EV_MAC   = 4'd4;
    localparam pte_pc_t STEP_EV_DONE  = 4'd5;
    localparam pte_pc_t STEP_W_LL     = 4'd6;
    localparam pte_pc_t STEP_W_LH     = 4'd7;
    localparam pte_pc_t STEP_W_HL     = 4'd8;
    localparam pte_pc_t STEP_W_ACC    = 4'd9;
    localparam pte_pc_t STEP_W_DONE   = 4'd10;

    typedef struct packed {
        pte_op_t  op;
        pte_jmp_t jmp;
        pte_pc_t  target;
    } pte_uword_t;

    typedef struct packed {
        logic is_eval;
        logic more;
        logic wide;
    } pte_status_t;

    function automatic pte_uword_t ucode_rom(input pte_pc_t pc);
        pte_uword_t w;
        w = '{op: OP_NOP, jmp: JMP_ALWAYS, target: STEP_IDLE};
        case (pc)
            STEP_DISPATCH: w = '{op: OP_RD_TERM, jmp: JMP_IF_EVAL, target: STEP_EV_INIT};
            STEP_WRITE:    w = '{op: OP_WR_TERM, jmp: JMP_ALWAYS,  target: STEP_IDLE};
            STEP_EV_INIT:  w = '{op: OP_EV_INIT, jmp: JMP_IF_WIDE, target: STEP_W_LL};
            STEP_EV_MAC:   w = '{op: OP_EV_MAC,  jmp: JMP_IF_MORE, target: STEP_EV_MAC};
            STEP_EV_DONE:  w = '{op: OP_EV_DONE, jmp: JMP_ALWAYS,  target: STEP_IDLE};
            STEP_W_LL:     w = '{op: OP_W_LL,    jmp: JMP_NEXT,    target: STEP_IDLE};
            STEP_W_LH:     w = '{op: OP_W_LH,    jmp: JMP_NEXT,    target: STEP_IDLE};
            STEP_W_HL:     w = '{op: OP_W_HL,    jmp: JMP_NEXT,    target: STEP_IDLE};
            STEP_W_ACC:    w = '{op: OP_W_ACC,   jmp: JMP_IF_MORE, target: STEP_W_LL};
            STEP_W_DONE:   w = '{op: OP_EV_DONE, jmp: JMP_ALWAYS,  target: STEP_IDLE};
            default:       w = '{op: OP_NOP,     jmp: JMP_ALWAYS,  target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/polynomial_term_accumulate_evaluate.sv
// Top level of the polynomial term accumulator and evaluator.
// Instantiates pte_sequencer and pte_datapath; uses pte_pkg and the defines header.
//
//   Channel   Handshake               Payload
//   request   start, busy             pte_in_t  (command, coefficient, exponent, x)
//   result    done (one-cycle strobe) pte_out_t (eval_point, eval_value)
//
// An add-term item keeps busy high through its dispatch and write steps.
// An evaluate item keeps busy high through dispatch, init, one Horner pass per table
// entry through the single multiplier, and the done step; when VALUE_WIDTH is above
// 32, each pass runs the split steps W_LL, W_LH, W_HL and W_ACC.
// The result strobe comes in the last busy cycle; the receiver cannot stall it.
// Reset clears the valid bits of all table entries at once, with no clearing pass.
`default_nettype none
`include "polynomial_term_accumulate_evaluate_defines.svh"

module polynomial_term_accumulate_evaluate #(
    parameter int MAX_DEGREE  = 15,
    parameter int VALUE_WIDTH = 32
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    output logic                    busy,
    input  wire pte_pkg::pte_in_t   request,
    output logic                    done,
    output pte_pkg::pte_out_t       result
);

    pte_pkg::pte_uword_t  ctrl;
    pte_pkg::pte_status_t status;
    logic                 capture;

    assign capture = start && !busy;
    assign done    = (ctrl.op == pte_pkg::OP_EV_DONE);

    pte_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .ctrl   (ctrl)
    );

    pte_datapath #(
        .MAX_DEGREE  (MAX_DEGREE),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .capture (capture),
        .request (request),
        .ctrl    (ctrl),
        .status  (status),
        .result  (result)
    );

    `PTE_ASSERT_SAME(a_done_while_busy, done, busy)
    `PTE_ASSERT_NEXT(a_accept_sets_busy, capture, busy)
    `PTE_ASSERT_NEXT(a_done_ends_item, done, !busy)
    `PTE_ASSERT_NEXT(a_add_gives_no_result, capture && (request.command == pte_pkg::CMD_ADD_TERM), !done)

endmodule

`default_nettype wire

// File: rtl/pte_sequencer.sv
// Microcode sequencer: step counter, control word lookup and jump logic.
// Depends on pte_pkg for the control word, status struct and table.
`default_nettype none

module pte_sequencer (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       start,
    input  wire pte_pkg::pte_status_t status,
    output logic                      busy,
    output pte_pkg::pte_uword_t       ctrl
);

    pte_pkg::pte_pc_t pc_reg;
    pte_pkg::pte_pc_t pc_next;
    pte_pkg::pte_pc_t pc_inc;

    assign ctrl   = pte_pkg::ucode_rom(pc_reg);
    assign busy   = (pc_reg != pte_pkg::STEP_IDLE);
    assign pc_inc = pc_reg + pte_pkg::pte_pc_t'(1);

    always_comb
    begin
        pc_next = pc_inc;
        if (!busy)
        begin
            pc_next = start ? pte_pkg::STEP_DISPATCH : pte_pkg::STEP_IDLE;
        end
        else
        begin
            case (ctrl.jmp)
                pte_pkg::JMP_NEXT:    pc_next = pc_inc;
                pte_pkg::JMP_ALWAYS:  pc_next = ctrl.target;
                pte_pkg::JMP_IF_EVAL: pc_next = status.is_eval ? ctrl.target : pc_inc;
                pte_pkg::JMP_IF_WIDE: pc_next = status.wide ? ctrl.target : pc_inc;
                pte_pkg::JMP_IF_MORE: pc_next = status.more ? ctrl.target : pc_inc;
                default:              pc_next = pte_pkg::STEP_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= pte_pkg::STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pte_datapath.sv
// Datapath: item register, coefficient memory with valid bits, one shared
// multiplier and the Horner accumulator. Depends on pte_pkg.
`default_nettype none

module pte_datapath #(
    parameter int MAX_DEGREE  = 15,
    parameter int VALUE_WIDTH = 32
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       capture,
    input  wire pte_pkg::pte_in_t     request,
    input  wire pte_pkg::pte_uword_t  ctrl,
    output pte_pkg::pte_status_t      status,
    output pte_pkg::pte_out_t         result
);

    localparam int  DEPTH = MAX_DEGREE + 1;
    localparam int  AW    = $clog2(DEPTH);
    localparam int  W     = VALUE_WIDTH;
    localparam bit  WIDE  = (VALUE_WIDTH > 32);
    localparam int  HALF  = (VALUE_WIDTH + 1) / 2;
    localparam int  MW    = WIDE ? HALF : VALUE_WIDTH;

    pte_pkg::pte_in_t item_reg;

    logic [W-1:0]      mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [W-1:0]      rd_data_reg;
    logic              rd_valid_reg;
    logic [AW-1:0]     rd_addr;

    logic [W-1:0]      acc_reg;
    logic [W-1:0]      prod_reg;
    logic [AW-1:0]     k_reg;

    logic [W-1:0]      coef_in;
    logic [W-1:0]      coef_eff;
    logic [W-1:0]      x_w;
    logic [AW-1:0]     term_addr;
    logic              term_ok;
    logic [MW-1:0]     op_a;
    logic [MW-1:0]     op_b;
    logic [2*MW-1:0]   prod;
    logic [W-1:0]      prod_w;

    assign coef_in   = W'(item_reg.term_coefficient);
    assign x_w       = W'(item_reg.point_x);
    assign coef_eff  = rd_valid_reg ? rd_data_reg : '0;
    assign term_addr = AW'(item_reg.term_exponent);
    assign term_ok   = ({28'd0, item_reg.term_exponent} <= 32'(MAX_DEGREE));

    always_comb
    begin
        case (ctrl.op)
            pte_pkg::OP_RD_TERM: rd_addr = term_addr;
            pte_pkg::OP_EV_INIT: rd_addr = AW'(MAX_DEGREE);
            pte_pkg::OP_EV_MAC:  rd_addr = k_reg - AW'(1);
            pte_pkg::OP_W_ACC:   rd_addr = k_reg - AW'(1);
            default:             rd_addr = k_reg;
        endcase
    end

    always_comb
    begin
        case (ctrl.op)
            pte_pkg::OP_W_LH:
            begin
                op_a = MW'(acc_reg);
                op_b = MW'(x_w >> HALF);
            end
            pte_pkg::OP_W_HL:
            begin
                op_a = MW'(acc_reg >> HALF);
                op_b = MW'(x_w);
            end
            default:
            begin
                op_a = MW'(acc_reg);
                op_b = MW'(x_w);
            end
        endcase
    end

    assign prod   = (2*MW)'(op_a) * (2*MW)'(op_b);
    assign prod_w = W'(prod);

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            item_reg <= request;
        end
        rd_data_reg <= mem[rd_addr];
        if ((ctrl.op == pte_pkg::OP_WR_TERM) && term_ok)
        begin
            mem[term_addr] <= coef_eff + coef_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if ((ctrl.op == pte_pkg::OP_WR_TERM) && term_ok)
            begin
                valid_reg[term_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            pte_pkg::OP_EV_INIT:
            begin
                acc_reg <= '0;
                k_reg   <= AW'(MAX_DEGREE);
            end
            pte_pkg::OP_EV_MAC:
            begin
                acc_reg <= prod_w + coef_eff;
                k_reg   <= k_reg - AW'(1);
            end
            pte_pkg::OP_W_LL:
            begin
                prod_reg <= prod_w;
            end
            pte_pkg::OP_W_LH, pte_pkg::OP_W_HL:
            begin
                prod_reg <= prod_reg + (prod_w << HALF);
            end
            pte_pkg::OP_W_ACC:
            begin
                acc_reg <= prod_reg + coef_eff;
                k_reg   <= k_reg - AW'(1);
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign status.is_eval     = (item_reg.command == pte_pkg::CMD_EVALUATE);
    assign status.more        = (k_reg != '0);
    assign status.wide        = WIDE;
    assign result.eval_point  = item_reg.point_x;
    assign result.eval_value  = 32'(acc_reg);

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for polynomial_term_accumulate_evaluate.
// Drives add-term and evaluate items and checks every result against a Horner predictor.
// Depends on pte_pkg and the top-level RTL only.
`default_nettype none

module testbench;

    import pte_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned SETTLE_CYCLES = 80;
    localparam int unsigned RANDOM_ITEMS = 1430;

    class poly_scoreboard;
        logic [31:0] coeffs [16];
        pte_out_t    pending_q [$];
        int unsigned n_errors;
        int unsigned n_terms;
        int unsigned n_evals;

        function new();
            foreach (coeffs[k])
            begin
                coeffs[k] = '0;
            end
            n_errors = 0;
            n_terms = 0;
            n_evals = 0;
        endfunction

        function logic [31:0] horner_value(logic [31:0] x);
            logic [31:0] acc;
            int          k;
            acc = '0;
            for (k = 15; k >= 0; k--)
            begin
                acc = acc * x + coeffs[4'(k)];
            end
            return acc;
        endfunction

        function void note_item(pte_in_t item);
            pte_out_t expected;
            if (item.command == CMD_ADD_TERM)
            begin
                coeffs[item.term_exponent] = coeffs[item.term_exponent] + item.term_coefficient;
                n_terms++;
            end
            else
            begin
                expected.eval_point = item.point_x;
                expected.eval_value = horner_value(item.point_x);
                pending_q.push_back(expected);
            end
        endfunction

        function void check_result(pte_out_t got);
            pte_out_t expected;
            if (pending_q.size() == 0)
            begin
                $error("result with no evaluation pending: eval_point %0d, eval_value %0d",
                       got.eval_point, got.eval_value);
                n_errors++;
                return;
            end
            expected = pending_q.pop_front();
            n_evals++;
            if (got.eval_point !== expected.eval_point)
            begin
                $error("eval_point: expected %0d, got %0d", expected.eval_point, got.eval_point);
                n_errors++;
            end
            if (got.eval_value !== expected.eval_value)
            begin
                $error("eval_value: expected %0d, got %0d", expected.eval_value, got.eval_value);
                n_errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    pte_in_t     request;
    pte_out_t    result;
    int unsigned cycles;

    poly_scoreboard sb = new();

    polynomial_term_accumulate_evaluate i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                sb.check_result(result);
            end
            if (start && !busy)
            begin
                sb.note_item(request);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word(int unsigned small_pct, int unsigned edge_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < small_pct)
        begin
            return $urandom_range(200) - 100;
        end
        if (r < small_pct + edge_pct)
        begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom;
    endfunction

    function automatic pte_in_t make_item(logic cmd, logic [31:0] coef, logic [3:0] expo,
                                          logic [31:0] x);
        pte_in_t item;
        item.command = cmd;
        item.term_coefficient = coef;
        item.term_exponent = expo;
        item.point_x = x;
        return item;
    endfunction

    task automatic send_item(pte_in_t item, int unsigned idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            request <= make_item(1'($urandom), $urandom, 4'($urandom), $urandom);
            @(posedge clk);
        end
        start <= 1'b1;
        request <= item;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.pending_q.size() != 0);
    endtask

    task automatic run_directed();
        send_item(make_item(CMD_EVALUATE, 32'h1234_5678, 4'hf, 32'h0000_0000), 0);
        send_item(make_item(CMD_EVALUATE, 32'hffff_ffff, 4'h3, 32'h8000_0000), 0);
        send_item(make_item(CMD_ADD_TERM, 32'h7fff_ffff, 4'h0, 32'hffff_ffff), 0);
        send_item(make_item(CMD_ADD_TERM, 32'h7fff_ffff, 4'h0, 32'h0000_0000), 0);
        send_item(make_item(CMD_ADD_TERM, 32'h8000_0000, 4'hf, 32'h7fff_ffff), 0);
        send_item(make_item(CMD_ADD_TERM, 32'hffff_ffff, 4'hf, 32'h8000_0000), 0);
        send_item(make_item(CMD_ADD_TERM, 32'h0000_0001, 4'h7, 32'h5a5a_5a5a), 0);
        send_item(make_item(CMD_EVALUATE, 32'h0000_0000, 4'h0, 32'h0000_0000), 0);
        send_item(make_item(CMD_EVALUATE, 32'h0000_0000, 4'h0, 32'h0000_0001), 0);
        send_item(make_item(CMD_EVALUATE, 32'h0000_0000, 4'h0, 32'hffff_ffff), 0);
        send_item(make_item(CMD_EVALUATE, 32'h0000_0000, 4'h0, 32'h7fff_ffff), 0);
        send_item(make_item(CMD_EVALUATE, 32'h0000_0000, 4'h0, 32'h8000_0000), 0);
        send_item(make_item(CMD_ADD_TERM, 32'h8000_0000, 4'h1, 32'h0000_0000), 0);
        send_item(make_item(CMD_ADD_TERM, 32'h8000_0000, 4'h1, 32'h0000_0000), 0);
        send_item(make_item(CMD_ADD_TERM, 32'h5a5a_5a5a, 4'h3, 32'h0000_0000), 0);
        send_item(make_item(CMD_ADD_TERM, 32'ha5a5_a5a5, 4'hc, 32'h0000_0000), 0);
        send_item(make_item(CMD_EVALUATE, 32'h7fff_ffff, 4'hf, 32'h0000_0002), 0);
        send_item(make_item(CMD_EVALUATE, 32'h8000_0000, 4'h0, 32'hffff_fffe), 0);
        send_item(make_item(CMD_EVALUATE, 32'h0000_0000, 4'h0, 32'h0001_0000), 0);
        send_item(make_item(CMD_EVALUATE, 32'h0000_0000, 4'h0, 32'hdead_beef), 0);
    endtask

    task automatic run_random(int unsigned count, int unsigned idle_pct);
        int unsigned n;
        logic        cmd;
        for (n = 0; n < count; n++)
        begin
            cmd = ($urandom_range(99) < 60) ? CMD_ADD_TERM : CMD_EVALUATE;
            send_item(make_item(cmd, pick_word(40, 10), 4'($urandom), pick_word(40, 15)),
                      idle_pct);
        end
    endtask

    initial
    begin
        int unsigned idle_pcts [4];
        int unsigned p;
        idle_pcts = '{0, 57, 7, 57};
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain_results();
        for (p = 0; p < 4; p++)
        begin
            run_random(RANDOM_ITEMS / 4, idle_pcts[p]);
            drain_results();
            repeat ($urandom_range(30)) @(posedge clk);
        end

        start <= 1'b0;
        while (sb.pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Added %0d terms and checked %0d evaluations under four pacing phases.",
                 sb.n_terms, sb.n_evals);
        $display("Mismatches found: %0d.", sb.n_errors);
        if (sb.n_errors == 0 && sb.pending_q.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
